/* rtl/rks_pkg.sv */
// Shared types, constants and helper functions of the random keystroke sequencer.
package rks_pkg;

   // Widths fixed by the register map and the item fields
   localparam int RND_W      = 16;
   localparam int DIV_CNT_W  = $clog2(RND_W + 1);
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CODE_W     = 8;
   localparam int MIN_DLY_W  = 15;

   localparam logic [RND_W-1:0] SEED_FALLBACK = 16'hA5A5;
   localparam logic [RND_W-1:0] LETTER_COUNT  = 16'd26;
   localparam logic [RND_W-1:0] TICKS_MAX     = 16'hFFFF;

   // Reset values of the configuration registers
   localparam logic [RND_W-1:0]     HOLD_RESET        = 16'd8;
   localparam logic [MIN_DLY_W-1:0] MIN_DELAY_RESET   = 15'd1190;
   localparam logic [RND_W-1:0]     SPAN_RESET        = 16'd2380;
   localparam logic [RND_W-1:0]     WAIT_LIMIT_RESET  = 16'd11904;
   localparam logic [CODE_W-1:0]    LETTER_BASE_RESET = 8'd4;
   localparam logic [CODE_W-1:0]    ERASE_CODE_RESET  = 8'd42;

   typedef enum logic [2:0] {
      REG_HOLD        = 3'd0,
      REG_MIN_DELAY   = 3'd1,
      REG_SPAN        = 3'd2,
      REG_WAIT_LIMIT  = 3'd3,
      REG_LETTER_BASE = 3'd4,
      REG_ERASE_CODE  = 3'd5
   } reg_idx_type;

   typedef enum logic [1:0] {
      FUNC_TICK = 2'd0,
      FUNC_ARM  = 2'd1,
      FUNC_KEY  = 2'd2,
      FUNC_POLL = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      MODE_OFF  = 2'd0,
      MODE_WAIT = 2'd1,
      MODE_RUN  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      STEP_LETTER_DOWN = 2'd0,
      STEP_LETTER_UP   = 2'd1,
      STEP_ERASE_DOWN  = 2'd2,
      STEP_ERASE_UP    = 2'd3
   } step_type;

   typedef struct packed {
      logic [RND_W-1:0]     hold;
      logic [MIN_DLY_W-1:0] min_delay;
      logic [RND_W-1:0]     span;
      logic [RND_W-1:0]     wait_limit;
      logic [CODE_W-1:0]    letter_base;
      logic [CODE_W-1:0]    erase_code;
   } cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic start_div;
      logic commit;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic needs_div;
      logic div_done;
      logic out_free;
   } dp_status_type;

   // One step of the 16-bit xorshift generator (left 7, right 9, left 8)
   function automatic logic [RND_W-1:0] xorshift16(input logic [RND_W-1:0] value);
      logic [RND_W-1:0] a;
      logic [RND_W-1:0] b;
      a = value ^ (value << 7);
      b = a ^ (a >> 9);
      return b ^ (b << 8);
   endfunction

endpackage

/* rtl/rks_csr.sv */
// Configuration register bank with an APB-style write and read port.
module rks_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [rks_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [rks_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [rks_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output rks_pkg::cfg_type                 cfg
);
   import rks_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type idx;
   logic        wr_en;

   assign idx        = reg_idx_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Decode the write transfer into the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_HOLD:        cfg_in.hold        = csr_pwdata[RND_W-1:0];
            REG_MIN_DELAY:   cfg_in.min_delay   = csr_pwdata[MIN_DLY_W-1:0];
            REG_SPAN:        cfg_in.span        = csr_pwdata[RND_W-1:0];
            REG_WAIT_LIMIT:  cfg_in.wait_limit  = csr_pwdata[RND_W-1:0];
            REG_LETTER_BASE: cfg_in.letter_base = csr_pwdata[CODE_W-1:0];
            REG_ERASE_CODE:  cfg_in.erase_code  = csr_pwdata[CODE_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold        <= HOLD_RESET;
         cfg_ff.min_delay   <= MIN_DELAY_RESET;
         cfg_ff.span        <= SPAN_RESET;
         cfg_ff.wait_limit  <= WAIT_LIMIT_RESET;
         cfg_ff.letter_base <= LETTER_BASE_RESET;
         cfg_ff.erase_code  <= ERASE_CODE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the addressed register
   always_comb begin
      case (idx)
         REG_HOLD:        csr_prdata = CSR_DATA_W'(cfg_ff.hold);
         REG_MIN_DELAY:   csr_prdata = CSR_DATA_W'(cfg_ff.min_delay);
         REG_SPAN:        csr_prdata = CSR_DATA_W'(cfg_ff.span);
         REG_WAIT_LIMIT:  csr_prdata = CSR_DATA_W'(cfg_ff.wait_limit);
         REG_LETTER_BASE: csr_prdata = CSR_DATA_W'(cfg_ff.letter_base);
         REG_ERASE_CODE:  csr_prdata = CSR_DATA_W'(cfg_ff.erase_code);
         default:         csr_prdata = '0;
      endcase
   end

endmodule

/* rtl/rks_div.sv */
// Bit-serial restoring remainder unit: one quotient bit per cycle.
module rks_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [rks_pkg::RND_W-1:0]   dividend,
   input  logic [rks_pkg::RND_W-1:0]   divisor,
   output logic                        done,
   output logic [rks_pkg::RND_W-1:0]   remainder
);
   import rks_pkg::*;

   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_CNT_W-1:0] cnt_in;
   logic [RND_W-1:0]     rem_ff;
   logic [RND_W-1:0]     rem_in;
   logic [RND_W-1:0]     quo_ff;
   logic [RND_W-1:0]     quo_in;
   logic [RND_W:0]       trial;
   logic [RND_W:0]       div_ext;

   assign trial   = {rem_ff, quo_ff[RND_W-1]};
   assign div_ext = {1'b0, divisor};

   // Shift in the next dividend bit and subtract where it fits
   always_comb begin
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (start) begin
         cnt_in = DIV_CNT_W'(RND_W);
         rem_in = '0;
         quo_in = dividend;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         quo_in = {quo_ff[RND_W-2:0], 1'b0};
         if (trial >= div_ext) begin
            rem_in = RND_W'(trial - div_ext);
         end else begin
            rem_in = trial[RND_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done      = (cnt_ff == '0);
   assign remainder = rem_ff;

endmodule

/* rtl/rks_dp.sv */
// Datapath: item capture, sequencer state, random draw and result register.
module rks_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  rks_pkg::ctrl_cmd_type        cmd,
   output rks_pkg::dp_status_type       status,
   input  rks_pkg::cfg_type             cfg,
   input  logic [1:0]                   req_func,
   input  logic [rks_pkg::RND_W-1:0]    req_seed,
   input  logic                         req_pressed,
   input  logic                         req_matrix_busy,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_report_sent,
   output logic [rks_pkg::CODE_W-1:0]   rsp_letter_key,
   output logic                         rsp_erase_down,
   output logic                         rsp_running,
   output logic                         rsp_swallowed,
   output logic                         rsp_keep_awake
);
   import rks_pkg::*;

   // Captured item
   func_type         func_ff;
   logic [RND_W-1:0] seed_ff;
   logic             pressed_ff;
   logic             busy_ff;

   // Sequencer state
   mode_type         mode_ff,   mode_in;
   step_type         step_ff,   step_in;
   logic [CODE_W-1:0] held_ff,  held_in;
   logic [RND_W-1:0] rng_ff,    rng_in;
   logic [RND_W-1:0] cd_ff,     cd_in;
   logic             due_ff,    due_in;
   logic             saw_ff,    saw_in;

   // Result register
   logic             out_valid_ff, out_valid_in;
   logic             sent_ff,   sent_in;
   logic             erase_ff,  erase_in;
   logic             run_ff,    run_in;
   logic             swal_ff,   swal_in;
   logic             awake_ff,  awake_in;

   logic [RND_W-1:0] rnd_next;
   logic [RND_W-1:0] divisor;
   logic             div_done;
   logic [RND_W-1:0] rem_q;
   logic [RND_W-1:0] extra;
   logic [RND_W:0]   delay_sum;
   logic [RND_W-1:0] delay;

   assign rnd_next = xorshift16(rng_ff);
   assign divisor  = (step_ff == STEP_LETTER_DOWN) ? LETTER_COUNT : cfg.span;

   rks_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.start_div),
      .dividend  (rnd_next),
      .divisor   (divisor),
      .done      (div_done),
      .remainder (rem_q)
   );

   // Saturating delay: minimum plus the random extra
   assign extra     = (cfg.span == '0) ? '0 : rem_q;
   assign delay_sum = {2'b00, cfg.min_delay} + {1'b0, extra};
   assign delay     = delay_sum[RND_W] ? TICKS_MAX : delay_sum[RND_W-1:0];

   // Report status to the controller
   assign status.needs_div = (func_ff == FUNC_POLL) && (mode_ff == MODE_RUN) && !busy_ff
                             && due_ff && (step_ff != STEP_ERASE_DOWN);
   assign status.div_done  = div_done;
   assign status.out_free  = !out_valid_ff || rsp_ready;

   // Next sequencer state and result for the captured item
   always_comb begin
      mode_in  = mode_ff;
      step_in  = step_ff;
      held_in  = held_ff;
      rng_in   = rng_ff;
      cd_in    = cd_ff;
      due_in   = due_ff;
      saw_in   = saw_ff;
      sent_in  = 1'b0;
      swal_in  = 1'b0;
      awake_in = 1'b0;
      if (cmd.start_div) begin
         rng_in = rnd_next;
      end
      if (cmd.commit) begin
         case (func_ff)
            FUNC_TICK: begin
               if (cd_ff != '0) begin
                  cd_in = cd_ff - 1'b1;
                  if (cd_ff == RND_W'(1)) begin
                     due_in = 1'b1;
                  end
               end
            end
            FUNC_ARM: begin
               if (mode_ff == MODE_OFF) begin
                  rng_in  = (seed_ff == '0) ? SEED_FALLBACK : seed_ff;
                  held_in = '0;
                  mode_in = MODE_WAIT;
                  saw_in  = 1'b1;
                  cd_in   = cfg.wait_limit;
                  due_in  = 1'b0;
               end
            end
            FUNC_KEY: begin
               if (mode_ff != MODE_OFF) begin
                  swal_in = 1'b1;
                  if (mode_ff == MODE_RUN && pressed_ff) begin
                     // cancel the run
                     held_in = '0;
                     cd_in   = cfg.wait_limit;
                     due_in  = 1'b0;
                     mode_in = MODE_WAIT;
                     saw_in  = 1'b0;
                     sent_in = 1'b1;
                  end
               end
            end
            default: begin
               if (mode_ff == MODE_WAIT) begin
                  if (busy_ff) begin
                     if (due_ff) begin
                        mode_in = MODE_OFF;
                     end
                  end else if (saw_ff) begin
                     mode_in = MODE_RUN;
                     step_in = STEP_LETTER_DOWN;
                     due_in  = 1'b1;
                  end else begin
                     mode_in = MODE_OFF;
                  end
               end else if (mode_ff == MODE_RUN) begin
                  if (busy_ff) begin
                     // cancel the run
                     held_in = '0;
                     cd_in   = cfg.wait_limit;
                     due_in  = 1'b0;
                     mode_in = MODE_WAIT;
                     saw_in  = 1'b0;
                     sent_in = 1'b1;
                  end else if (due_ff) begin
                     due_in   = 1'b0;
                     awake_in = 1'b1;
                     sent_in  = 1'b1;
                     case (step_ff)
                        STEP_LETTER_DOWN: begin
                           held_in = CODE_W'(cfg.letter_base + rem_q[CODE_W-1:0]);
                           cd_in   = cfg.hold;
                           step_in = STEP_LETTER_UP;
                        end
                        STEP_LETTER_UP: begin
                           held_in = '0;
                           cd_in   = delay;
                           step_in = STEP_ERASE_DOWN;
                        end
                        STEP_ERASE_DOWN: begin
                           cd_in   = cfg.hold;
                           step_in = STEP_ERASE_UP;
                        end
                        default: begin
                           cd_in   = delay;
                           step_in = STEP_LETTER_DOWN;
                        end
                     endcase
                  end
               end
            end
         endcase
      end
      erase_in = (mode_in == MODE_RUN) && (step_in == STEP_ERASE_UP);
      run_in   = (mode_in == MODE_RUN);
   end

   // Hold the result until its transfer completes
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.commit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_OFF;
         step_ff      <= STEP_LETTER_DOWN;
         held_ff      <= '0;
         rng_ff       <= '0;
         cd_ff        <= '0;
         due_ff       <= 1'b0;
         saw_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         step_ff      <= step_in;
         held_ff      <= held_in;
         rng_ff       <= rng_in;
         cd_ff        <= cd_in;
         due_ff       <= due_in;
         saw_ff       <= saw_in;
         out_valid_ff <= out_valid_in;
      end
      if (cmd.capture) begin
         func_ff    <= func_type'(req_func);
         seed_ff    <= req_seed;
         pressed_ff <= req_pressed;
         busy_ff    <= req_matrix_busy;
      end
      if (cmd.commit) begin
         sent_ff  <= sent_in;
         erase_ff <= erase_in;
         run_ff   <= run_in;
         swal_ff  <= swal_in;
         awake_ff <= awake_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_report_sent = sent_ff;
   assign rsp_letter_key  = held_ff;
   assign rsp_erase_down  = erase_ff;
   assign rsp_running     = run_ff;
   assign rsp_swallowed   = swal_ff;
   assign rsp_keep_awake  = awake_ff;

endmodule

/* rtl/rks_ctrl.sv */
// Controller: sequences capture, random draw and commit of one item.
module rks_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  rks_pkg::dp_status_type  status,
   output rks_pkg::ctrl_cmd_type   cmd
);
   import rks_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV,
      ST_COMMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Pick the next state from datapath status
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = status.needs_div ? ST_DIV : ST_COMMIT;
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Issue commands
   assign req_ready     = (state_ff == ST_IDLE);
   assign cmd.capture   = (state_ff == ST_IDLE) && req_valid;
   assign cmd.start_div = (state_ff == ST_EVAL) && status.needs_div;
   assign cmd.commit    = (state_ff == ST_COMMIT) && status.out_free;

endmodule

/* rtl/random_keystroke_sequencer_top.sv */
// Top level of the random keystroke sequencer: controller, datapath and registers.
// An item is captured in ST_IDLE, evaluated in ST_EVAL and registered as a result on
// commit in ST_COMMIT; a run step that draws a random letter or delay passes through
// ST_DIV between evaluation and commit, in the bit-serial remainder unit. A new item
// is taken only after the previous commit, while that result waits in the output register.
// Reset: synchronous, active high; clears mode, step, generator, countdown and
// the result valid, and loads the register defaults.
module random_keystroke_sequencer_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_func,
   input  logic [rks_pkg::RND_W-1:0]        req_seed,
   input  logic                             req_pressed,
   input  logic                             req_matrix_busy,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_report_sent,
   output logic [rks_pkg::CODE_W-1:0]       rsp_letter_key,
   output logic                             rsp_erase_down,
   output logic                             rsp_running,
   output logic                             rsp_swallowed,
   output logic                             rsp_keep_awake,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [rks_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [rks_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [rks_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import rks_pkg::*;

   cfg_type       cfg;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   rks_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rks_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rks_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .cfg             (cfg),
      .req_func        (req_func),
      .req_seed        (req_seed),
      .req_pressed     (req_pressed),
      .req_matrix_busy (req_matrix_busy),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_report_sent (rsp_report_sent),
      .rsp_letter_key  (rsp_letter_key),
      .rsp_erase_down  (rsp_erase_down),
      .rsp_running     (rsp_running),
      .rsp_swallowed   (rsp_swallowed),
      .rsp_keep_awake  (rsp_keep_awake)
   );

endmodule

/* rtl/rks_checker.sv */
// Port-level checks of the random keystroke sequencer, bound to the top level.
module rks_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_report_sent,
   input logic [7:0] rsp_letter_key,
   input logic       rsp_erase_down,
   input logic       rsp_running,
   input logic       rsp_swallowed,
   input logic       rsp_keep_awake
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_report_sent)
         && $stable(rsp_letter_key) && $stable(rsp_erase_down) && $stable(rsp_running)
         && $stable(rsp_swallowed) && $stable(rsp_keep_awake))
      else $error("result changed while stalled");

   // One item at a time: busy right after a transfer in
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after input transfer");

   // No result straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // Backspace is held only in run mode
   a_erase_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_erase_down |-> rsp_running)
      else $error("backspace held outside run");

   // A letter is held only in run mode
   a_letter_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_letter_key != 8'd0) |-> rsp_running)
      else $error("letter held outside run");

endmodule

bind random_keystroke_sequencer_top rks_checker u_rks_checker (.*);

/* verif/random_keystroke_sequencer_tb.sv */
// Testbench for the random keystroke sequencer: directed and random item streams checked against a predictor.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rks_pkg::*;

   localparam logic [15:0] SEED_SUBST    = 16'hA5A5;
   localparam logic [15:0] ALPHABET_SIZE = 16'd26;
   localparam int          NOISE_PCT     = 8;
   localparam int          SETTLE_CYCLES = 25;

   typedef struct packed {
      logic       report_sent;
      logic [7:0] letter_key;
      logic       erase_down;
      logic       running;
      logic       swallowed;
      logic       keep_awake;
   } key_report_t;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [1:0]            req_func;
   logic [RND_W-1:0]      req_seed;
   logic                  req_pressed;
   logic                  req_matrix_busy;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_report_sent;
   logic [CODE_W-1:0]     rsp_letter_key;
   logic                  rsp_erase_down;
   logic                  rsp_running;
   logic                  rsp_swallowed;
   logic                  rsp_keep_awake;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Predicted sequencer state and register mirror
   mode_type    seq_mode;
   step_type    seq_step;
   logic [7:0]  seq_letter;
   logic [15:0] seq_rng;
   logic [15:0] seq_countdown;
   logic        seq_due;
   logic        seq_auto_start;
   cfg_type     cfg_mirror;

   key_report_t pending_reports[$];
   int          mismatch_count;
   int          req_gap_pct;
   int          rsp_stall_pct;
   int          rsp_hold_cycles;
   bit          idle_off;

   random_keystroke_sequencer_top DUT (.*);

   initial begin : clock_gen
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin : watchdog
      #2000000;
      $display("random_keystroke_sequencer_top test failed");
      $finish;
   end

   function automatic void note_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("MISMATCH: %s", what);
   endfunction

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Advance the 16-bit xorshift (left 7, right 9, left 8)
   function automatic logic [15:0] draw_random();
      logic [15:0] v;
      v = seq_rng ^ (seq_rng << 7);
      v = v ^ (v >> 9);
      v = v ^ (v << 8);
      seq_rng = v;
      return v;
   endfunction

   // Minimum delay plus a random extra, saturated at 16 bits
   function automatic logic [15:0] draw_delay();
      logic [15:0] r;
      logic [16:0] total;
      r     = draw_random();
      total = {2'b00, cfg_mirror.min_delay};
      if (cfg_mirror.span != 16'd0) total = total + 17'(r % cfg_mirror.span);
      return (total > 17'h0FFFF) ? 16'hFFFF : total[15:0];
   endfunction

   // Drop all synthetic keys and fall back to wait without restart
   function automatic void abort_run();
      seq_letter     = 8'd0;
      seq_countdown  = cfg_mirror.wait_limit;
      seq_due        = 1'b0;
      seq_mode       = MODE_WAIT;
      seq_auto_start = 1'b0;
   endfunction

   function automatic key_report_t predict_report(func_type f, logic [15:0] seed,
                                                  logic pressed, logic busy);
      key_report_t rep;
      rep = '0;
      case (f)
         FUNC_TICK: begin
            if (seq_countdown != 16'd0) begin
               seq_countdown = seq_countdown - 16'd1;
               if (seq_countdown == 16'd0) seq_due = 1'b1;
            end
         end
         FUNC_ARM: begin
            if (seq_mode == MODE_OFF) begin
               seq_rng        = (seed == 16'd0) ? SEED_SUBST : seed;
               seq_letter     = 8'd0;
               seq_mode       = MODE_WAIT;
               seq_auto_start = 1'b1;
               seq_countdown  = cfg_mirror.wait_limit;
               seq_due        = 1'b0;
            end
         end
         FUNC_KEY: begin
            if (seq_mode != MODE_OFF) begin
               rep.swallowed = 1'b1;
               if (seq_mode == MODE_RUN && pressed) begin
                  abort_run();
                  rep.report_sent = 1'b1;
               end
            end
         end
         default: begin
            if (seq_mode == MODE_WAIT) begin
               if (busy) begin
                  if (seq_due) seq_mode = MODE_OFF;
               end else if (seq_auto_start) begin
                  seq_mode = MODE_RUN;
                  seq_step = STEP_LETTER_DOWN;
                  seq_due  = 1'b1;
               end else begin
                  seq_mode = MODE_OFF;
               end
            end else if (seq_mode == MODE_RUN) begin
               if (busy) begin
                  abort_run();
                  rep.report_sent = 1'b1;
               end else if (seq_due) begin
                  seq_due         = 1'b0;
                  rep.keep_awake  = 1'b1;
                  rep.report_sent = 1'b1;
                  case (seq_step)
                     STEP_LETTER_DOWN: begin
                        seq_letter    = cfg_mirror.letter_base
                                        + 8'(draw_random() % ALPHABET_SIZE);
                        seq_countdown = cfg_mirror.hold;
                        seq_step      = STEP_LETTER_UP;
                     end
                     STEP_LETTER_UP: begin
                        seq_letter    = 8'd0;
                        seq_countdown = draw_delay();
                        seq_step      = STEP_ERASE_DOWN;
                     end
                     STEP_ERASE_DOWN: begin
                        seq_countdown = cfg_mirror.hold;
                        seq_step      = STEP_ERASE_UP;
                     end
                     default: begin
                        seq_countdown = draw_delay();
                        seq_step      = STEP_LETTER_DOWN;
                     end
                  endcase
               end
            end
         end
      endcase
      rep.letter_key = seq_letter;
      rep.erase_down = (seq_mode == MODE_RUN && seq_step == STEP_ERASE_UP);
      rep.running    = (seq_mode == MODE_RUN);
      return rep;
   endfunction

   // ------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------

   // Hold off for a requested stretch, else stall in random bursts
   initial begin : result_ready_driver
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold_cycles = rsp_hold_cycles - 1;
         end else if (!idle_off && stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (!idle_off && $urandom_range(0, 99) < rsp_stall_pct)
               stall_left = $urandom_range(1, 14);
         end
      end
   end

   // Compare each result transfer with the oldest prediction
   always @(posedge clock) begin : result_checker
      key_report_t got;
      key_report_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_report_sent, rsp_letter_key, rsp_erase_down, rsp_running,
                rsp_swallowed, rsp_keep_awake};
         if (pending_reports.size() == 0) begin
            note_mismatch($sformatf("result with none predicted: %h", got));
         end else begin
            want = pending_reports.pop_front();
            if (got !== want)
               note_mismatch($sformatf({"expected sent=%0b letter=%0d erase=%0b run=%0b ",
                  "swallow=%0b awake=%0b, got sent=%0b letter=%0d erase=%0b run=%0b ",
                  "swallow=%0b awake=%0b"},
                  want.report_sent, want.letter_key, want.erase_down, want.running,
                  want.swallowed, want.keep_awake,
                  got.report_sent, got.letter_key, got.erase_down, got.running,
                  got.swallowed, got.keep_awake));
         end
      end
   end

   // ------------------------------------------------------------------
   // Item side
   // ------------------------------------------------------------------

   // Offer one item, hold it until the transfer, then queue its prediction
   task automatic send_item(func_type f, logic [15:0] seed, logic pressed, logic busy);
      key_report_t expected;
      int          gap;
      @(negedge clock);
      if (!idle_off && $urandom_range(0, 99) < req_gap_pct) begin
         gap = $urandom_range(1, 14);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= f;
      req_seed        <= seed;
      req_pressed     <= pressed;
      req_matrix_busy <= busy;
      expected = predict_report(f, seed, pressed, busy);
      do @(posedge clock); while (!req_ready);
      pending_reports.push_back(expected);
   endtask

   // Pick an item that moves the sequencer forward, with some noise mixed in
   task automatic send_random_item();
      func_type    f;
      logic [15:0] seed;
      logic        pressed;
      logic        busy;
      int          roll;
      roll    = $urandom_range(0, 99);
      seed    = ($urandom_range(0, 15) == 0) ? 16'h0000 : 16'($urandom);
      pressed = 1'($urandom_range(0, 1));
      busy    = 1'b0;
      if (roll < NOISE_PCT) begin
         f    = func_type'($urandom_range(0, 3));
         busy = 1'($urandom_range(0, 1));
      end else begin
         case (seq_mode)
            MODE_OFF: f = FUNC_ARM;
            MODE_WAIT: begin
               if (seq_auto_start) begin
                  f    = FUNC_POLL;
                  busy = (roll >= 90);
               end else if (roll < 70) begin
                  f = FUNC_TICK;
               end else begin
                  f    = FUNC_POLL;
                  busy = 1'($urandom_range(0, 1));
               end
            end
            default: begin
               if (seq_due) begin
                  f = FUNC_POLL;
               end else if (seq_countdown == 16'd0) begin
                  // stalled run: break it with a physical press
                  f       = FUNC_KEY;
                  pressed = 1'b1;
               end else begin
                  f = FUNC_TICK;
               end
            end
         endcase
      end
      send_item(f, seed, pressed, busy);
   endtask

   // Drop valid and wait until every predicted result has arrived
   task automatic wait_all_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Register port
   // ------------------------------------------------------------------

   task automatic csr_write(reg_idx_type idx, logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_HOLD:        cfg_mirror.hold        = value[15:0];
         REG_MIN_DELAY:   cfg_mirror.min_delay   = value[14:0];
         REG_SPAN:        cfg_mirror.span        = value[15:0];
         REG_WAIT_LIMIT:  cfg_mirror.wait_limit  = value[15:0];
         REG_LETTER_BASE: cfg_mirror.letter_base = value[7:0];
         default:         cfg_mirror.erase_code  = value[7:0];
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic csr_read_check(reg_idx_type idx);
      logic [31:0] want;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_HOLD:        want = 32'(cfg_mirror.hold);
         REG_MIN_DELAY:   want = 32'(cfg_mirror.min_delay);
         REG_SPAN:        want = 32'(cfg_mirror.span);
         REG_WAIT_LIMIT:  want = 32'(cfg_mirror.wait_limit);
         REG_LETTER_BASE: want = 32'(cfg_mirror.letter_base);
         default:         want = 32'(cfg_mirror.erase_code);
      endcase
      if (csr_prdata !== want)
         note_mismatch($sformatf("register %s read %h, expected %h",
                                 idx.name(), csr_prdata, want));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Write all registers once the block is idle, then read them back
   task automatic set_config(int hold, int min_dly, int span, int limit, int base, int erase);
      logic [31:0] vals [6];
      vals = '{hold, min_dly, span, limit, base, erase};
      wait_all_results();
      for (int i = 0; i < 6; i++) csr_write(reg_idx_type'(i), vals[i]);
      for (int i = 0; i < 6; i++) csr_read_check(reg_idx_type'(i));
   endtask

   function automatic int pick_idle_pct();
      int choices [4];
      choices = '{0, 10, 30, 60};
      return choices[$urandom_range(0, 3)];
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Defaults after reset; nothing acts while off
   task automatic test_idle_off_mode();
      for (int i = 0; i < 6; i++) csr_read_check(reg_idx_type'(i));
      send_item(FUNC_POLL, 16'h0000, 1'b0, 1'b1);
      send_item(FUNC_KEY, 16'h0000, 1'b1, 1'b0);
      send_item(FUNC_TICK, 16'hFFFF, 1'b0, 1'b0);
   endtask

   // Zero seed, ignored arm, letter wrap, zero delay stall, cancel and timeout
   task automatic test_arm_and_cancel();
      set_config(1, 0, 1, 2, 255, 255);
      send_item(FUNC_ARM, 16'h0000, 1'b0, 1'b0);
      send_item(FUNC_ARM, 16'h0005, 1'b0, 1'b0);
      send_item(FUNC_POLL, 16'h0000, 1'b0, 1'b1);
      send_item(FUNC_POLL, 16'h0000, 1'b0, 1'b0);
      send_item(FUNC_POLL, 16'h0000, 1'b0, 1'b0);
      send_item(FUNC_TICK, 16'h0000, 1'b0, 1'b0);
      send_item(FUNC_POLL, 16'h0000, 1'b0, 1'b0);
      send_item(FUNC_KEY, 16'h0000, 1'b0, 1'b0);
      send_item(FUNC_KEY, 16'h0000, 1'b1, 1'b0);
      send_item(FUNC_TICK, 16'h0000, 1'b0, 1'b0);
      send_item(FUNC_TICK, 16'h0000, 1'b0, 1'b0);
      send_item(FUNC_POLL, 16'h0000, 1'b0, 1'b1);
   endtask

   // Largest register values, delay saturation, zero wait limit, busy cancel
   task automatic test_register_extremes();
      set_config(1, 32767, 65535, 65535, 229, 0);
      send_item(FUNC_ARM, 16'h0001, 1'b0, 1'b0);
      send_item(FUNC_POLL, 16'h0000, 1'b0, 1'b0);
      send_item(FUNC_POLL, 16'h0000, 1'b0, 1'b0);
      send_item(FUNC_TICK, 16'h0000, 1'b0, 1'b0);
      send_item(FUNC_POLL, 16'h0000, 1'b0, 1'b0);
      send_item(FUNC_TICK, 16'h0000, 1'b0, 1'b0);
      send_item(FUNC_POLL, 16'h0000, 1'b0, 1'b0);
      send_item(FUNC_KEY, 16'h0000, 1'b1, 1'b0);
      set_config(65535, 0, 32768, 0, 0, 255);
      send_item(FUNC_POLL, 16'h0000, 1'b0, 1'b0);
      send_item(FUNC_ARM, 16'h8000, 1'b0, 1'b0);
      send_item(FUNC_TICK, 16'h0000, 1'b0, 1'b0);
      send_item(FUNC_TICK, 16'h0000, 1'b0, 1'b0);
      send_item(FUNC_POLL, 16'h0000, 1'b0, 1'b1);
      send_item(FUNC_POLL, 16'h0000, 1'b0, 1'b0);
      send_item(FUNC_POLL, 16'h0000, 1'b0, 1'b0);
      send_item(FUNC_TICK, 16'h0000, 1'b0, 1'b0);
      send_item(FUNC_POLL, 16'h0000, 1'b0, 1'b1);
   endtask

   // Full keystroke cycles under a fixed and several random settings
   task automatic test_random_phases();
      set_config(3, 2, 5, 6, 4, 42);
      req_gap_pct   = 20;
      rsp_stall_pct = 20;
      repeat (100) send_random_item();
      repeat (5) begin
         set_config($urandom_range(1, 4), $urandom_range(0, 6), $urandom_range(0, 8),
                    $urandom_range(0, 24), $urandom_range(0, 255), $urandom_range(0, 255));
         req_gap_pct   = pick_idle_pct();
         rsp_stall_pct = pick_idle_pct();
         repeat (110) send_random_item();
      end
   endtask

   // Zero hold and zero delay: every run stalls until cancelled
   task automatic test_zero_hold();
      set_config(0, 0, 0, 3, 97, 1);
      repeat (40) send_random_item();
   endtask

   // Hold off the result side for a long stretch while items keep coming
   task automatic test_output_backpressure();
      set_config(2, 1, 4, 5, 30, 40);
      req_gap_pct     = 0;
      rsp_hold_cycles = 300;
      repeat (60) send_random_item();
   endtask

   // Back-to-back transfers with no idling on either side
   task automatic test_full_rate();
      set_config($urandom_range(1, 3), $urandom_range(0, 4), $urandom_range(1, 6),
                 $urandom_range(1, 12), $urandom_range(0, 255), $urandom_range(0, 255));
      idle_off = 1'b1;
      repeat (150) send_random_item();
   endtask

   initial begin : main_sequence
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_func        = FUNC_TICK;
      req_seed        = '0;
      req_pressed     = 1'b0;
      req_matrix_busy = 1'b0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      mismatch_count  = 0;
      req_gap_pct     = 15;
      rsp_stall_pct   = 15;
      rsp_hold_cycles = 0;
      idle_off        = 1'b0;

      // model state after reset
      seq_mode               = MODE_OFF;
      seq_step               = STEP_LETTER_DOWN;
      seq_letter             = 8'd0;
      seq_rng                = 16'd0;
      seq_countdown          = 16'd0;
      seq_due                = 1'b0;
      seq_auto_start         = 1'b0;
      cfg_mirror.hold        = 16'd8;
      cfg_mirror.min_delay   = 15'd1190;
      cfg_mirror.span        = 16'd2380;
      cfg_mirror.wait_limit  = 16'd11904;
      cfg_mirror.letter_base = 8'd4;
      cfg_mirror.erase_code  = 8'd42;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_off_mode();
      test_arm_and_cancel();
      test_register_extremes();
      test_random_phases();
      test_zero_hold();
      test_output_backpressure();
      test_full_rate();
      wait_all_results();

      if (mismatch_count == 0)
         $display("random_keystroke_sequencer_top test passed");
      else
         $display("random_keystroke_sequencer_top test failed");
      $finish;
   end

endmodule

/* filelist.f */
rtl/rks_pkg.sv
rtl/rks_csr.sv
rtl/rks_div.sv
rtl/rks_dp.sv
rtl/rks_ctrl.sv
rtl/random_keystroke_sequencer_top.sv
rtl/rks_checker.sv
verif/random_keystroke_sequencer_tb.sv
